// ----- rtl/core/lsnr_pkg.sv -----
// ----------------------------------------------------------------------------
// lsnr_pkg: shared types and helpers for the source NAT rewrite unit
// Beat formats on the ports and along the rule cell chain, command codes,
// prefix mask and partial header checksum helpers.
// ----------------------------------------------------------------------------
package lsnr_pkg;

    localparam int RULE_SLOTS_DEF = 64;
    localparam int ADDR_W         = 32;
    localparam int HALF_W         = 16;
    localparam int SLOT_W         = 6;
    localparam int LEN_W          = 6;
    localparam int PSUM_W         = 19;   // seven halfwords
    localparam int SUM_W          = 20;   // nine halfwords
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(ADDR_W);

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_XLATE = 1'b1;

    typedef struct packed {
        logic              command;
        logic [SLOT_W-1:0] rule_slot;
        logic [ADDR_W-1:0] rule_prefix;
        logic [LEN_W-1:0]  rule_length;
        logic [ADDR_W-1:0] rule_new_address;
        logic              rule_enable;
        logic [31:0]       hdr_word0;
        logic [31:0]       hdr_word1;
        logic [31:0]       hdr_word2;
        logic [ADDR_W-1:0] source_address;
        logic [ADDR_W-1:0] dest_address;
    } t_in_item;

    typedef struct packed {
        logic              matched;
        logic [HALF_W-1:0] header_checksum;
        logic [ADDR_W-1:0] source_address_out;
    } t_out_item;

    // One beat as it travels down the chain of rule cells.
    typedef struct packed {
        logic              valid;
        logic              cmd;
        logic [SLOT_W-1:0] slot;
        logic [ADDR_W-1:0] prefix;
        logic [LEN_W-1:0]  len;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] target;
        logic              enable;
        logic [ADDR_W-1:0] src;
        logic [HALF_W-1:0] chk;
        logic [PSUM_W-1:0] psum;
        logic              hit;
        logic [LEN_W-1:0]  best_len;
        logic [ADDR_W-1:0] best_target;
    } t_beat;

    // Mask with the leading len bits set; len is already limited to 32.
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
        logic [ADDR_W-1:0] ones;
        ones = '1;
        if (len >= LEN_MAX) begin
            prefix_mask = '1;
        end else begin
            prefix_mask = ~(ones >> len);
        end
    endfunction

    // Sum of the header halfwords that do not depend on the source address.
    // The checksum halfword counts as zero.
    function automatic logic [PSUM_W-1:0] header_psum(
        input logic [31:0] w0,
        input logic [31:0] w1,
        input logic [31:0] w2,
        input logic [31:0] dst
    );
        header_psum = PSUM_W'(w0[31:16]) + PSUM_W'(w0[15:0])
                    + PSUM_W'(w1[31:16]) + PSUM_W'(w1[15:0])
                    + PSUM_W'(w2[31:16])
                    + PSUM_W'(dst[31:16]) + PSUM_W'(dst[15:0]);
    endfunction

endpackage

// ----- rtl/core/lsnr_rule_cell.sv -----
// ----------------------------------------------------------------------------
// lsnr_rule_cell: one rule slot of the translation table
// Holds one rule, takes a write aimed at its slot, and improves the best
// match carried by a translate beat before handing the beat on.
// ----------------------------------------------------------------------------
module lsnr_rule_cell #(
    parameter int CELL_INDEX = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lsnr_pkg::t_beat i_beat,
    output lsnr_pkg::t_beat o_beat
);
    import lsnr_pkg::*;

    logic              r_rule_valid;
    logic [ADDR_W-1:0] r_prefix;
    logic [ADDR_W-1:0] r_mask;
    logic [LEN_W-1:0]  r_len;
    logic [ADDR_W-1:0] r_target;
    t_beat             r_beat;
    t_beat             n_beat;

    logic wr_here;
    logic hit_here;

    assign wr_here = i_beat.valid && (i_beat.cmd == CMD_WRITE)
                  && (int'(i_beat.slot) == CELL_INDEX);

    // Strictly longer wins, so on equal lengths the earlier slot keeps it.
    assign hit_here = r_rule_valid
                   && (((i_beat.src ^ r_prefix) & r_mask) == '0)
                   && (!i_beat.hit || (r_len > i_beat.best_len));

    always_comb begin
        n_beat = i_beat;
        if (i_beat.valid && (i_beat.cmd == CMD_XLATE) && hit_here) begin
            n_beat.hit         = 1'b1;
            n_beat.best_len    = r_len;
            n_beat.best_target = r_target;
        end
        if (!i_rst_n) begin
            n_beat.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_here) begin
            r_prefix <= i_beat.prefix;
            r_mask   <= i_beat.mask;
            r_len    <= i_beat.len;
            r_target <= i_beat.target;
        end
        if (!i_rst_n) begin
            r_rule_valid <= 1'b0;
        end else if (wr_here) begin
            r_rule_valid <= i_beat.enable;
        end
    end

    always_ff @(posedge i_clk) begin
        r_beat <= n_beat;
    end

    assign o_beat = r_beat;

endmodule

// ----- rtl/core/lsnr_csum_out.sv -----
// ----------------------------------------------------------------------------
// lsnr_csum_out: checksum finish and result register
// On a hit, adds the chosen source address to the partial header sum, folds
// and inverts it; a miss passes through. One result per translate beat.
// ----------------------------------------------------------------------------
module lsnr_csum_out (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lsnr_pkg::t_beat     i_beat,
    output logic                o_valid,
    output lsnr_pkg::t_out_item o_result
);
    import lsnr_pkg::*;

    logic [SUM_W-1:0]  sum;
    logic [HALF_W:0]   fold1;
    logic [HALF_W-1:0] fold2;
    logic              r_valid;
    t_out_item         r_result;
    t_out_item         n_result;

    always_comb begin
        sum   = SUM_W'(i_beat.psum) + SUM_W'(i_beat.best_target[31:16])
              + SUM_W'(i_beat.best_target[15:0]);
        fold1 = (HALF_W+1)'(sum[HALF_W-1:0]) + (HALF_W+1)'(sum[SUM_W-1:HALF_W]);
        fold2 = fold1[HALF_W-1:0] + HALF_W'(fold1[HALF_W]);
        if (i_beat.hit) begin
            n_result.matched            = 1'b1;
            n_result.header_checksum    = ~fold2;
            n_result.source_address_out = i_beat.best_target;
        end else begin
            n_result.matched            = 1'b0;
            n_result.header_checksum    = i_beat.chk;
            n_result.source_address_out = i_beat.src;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_beat.valid && (i_beat.cmd == CMD_XLATE);
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ----- rtl/core/lpm_source_nat_rewrite_unit.sv -----
// ----------------------------------------------------------------------------
// lpm_source_nat_rewrite_unit: IPv4 source NAT by longest-prefix match
// Rule writes and header translations flow in order through a chain of
// rule cells, one cell per table slot, then through a checksum stage.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                      Transfer rule
//  --------  -------------------------  --------------------------------------
//  command   start, busy, i_cmd         beat taken when start is high, busy low
//  result    o_valid, o_result          beat shown for one cycle, no stall
//
// Every beat, write or translate, is taken into the entry register, so a new
// beat may be started on every clock while busy is low. A translate result
// passes through one entry register, one register per rule cell, and the
// checksum register. A write produces no result.
// Because writes and translates move through the cells in lockstep, every
// translate sees exactly the writes started before it.
// The synchronous reset empties the table by clearing each cell's valid
// bit and flushes all beats in flight; busy is a registered copy of reset.
// The result side cannot stall, so nothing in the chain ever holds.
// ----------------------------------------------------------------------------
module lpm_source_nat_rewrite_unit #(
    parameter int RULE_SLOTS = lsnr_pkg::RULE_SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  lsnr_pkg::t_in_item  i_cmd,
    output logic                o_valid,
    output lsnr_pkg::t_out_item o_result
);
    import lsnr_pkg::*;

    logic             r_busy;
    t_beat            r_entry;
    t_beat            n_entry;
    logic [LEN_W-1:0] sat_len;
    t_beat            w_chain [0:RULE_SLOTS];

    // Lengths above the address width saturate when the rule is written.
    assign sat_len = (i_cmd.rule_length > LEN_MAX) ? LEN_MAX : i_cmd.rule_length;

    // The entry stage also precomputes the mask and the part of the
    // checksum that does not depend on the replacement address.
    always_comb begin
        n_entry.valid       = i_rst_n && start && !r_busy;
        n_entry.cmd         = i_cmd.command;
        n_entry.slot        = i_cmd.rule_slot;
        n_entry.prefix      = i_cmd.rule_prefix;
        n_entry.len         = sat_len;
        n_entry.mask        = prefix_mask(sat_len);
        n_entry.target      = i_cmd.rule_new_address;
        n_entry.enable      = i_cmd.rule_enable;
        n_entry.src         = i_cmd.source_address;
        n_entry.chk         = i_cmd.hdr_word2[15:0];
        n_entry.psum        = header_psum(i_cmd.hdr_word0, i_cmd.hdr_word1,
                                          i_cmd.hdr_word2, i_cmd.dest_address);
        n_entry.hit         = 1'b0;
        n_entry.best_len    = '0;
        n_entry.best_target = '0;
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (!i_rst_n) begin
            r_busy        <= 1'b1;
        end else begin
            r_busy        <= 1'b0;
        end
    end

    assign busy       = r_busy;
    assign w_chain[0] = r_entry;

    // Slot 0 sits first, so on equal prefix lengths the lowest slot wins.
    for (genvar g = 0; g < RULE_SLOTS; g++) begin : g_cell
        lsnr_rule_cell #(
            .CELL_INDEX(g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_beat (w_chain[g]),
            .o_beat (w_chain[g+1])
        );
    end

    lsnr_csum_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (w_chain[RULE_SLOTS]),
        .o_valid (o_valid),
        .o_result(o_result)
    );

endmodule

// ----- rtl/core/lsnr_port_checker.sv -----
// ----------------------------------------------------------------------------
// lsnr_port_checker: port-level checks for the source NAT rewrite unit
// Ties each result to the translate command that caused it and checks the
// pass-through of headers that match no rule.
// ----------------------------------------------------------------------------
module lsnr_port_checker #(
    parameter int RULE_SLOTS = lsnr_pkg::RULE_SLOTS_DEF
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input lsnr_pkg::t_in_item  i_cmd,
    input logic                o_valid,
    input lsnr_pkg::t_out_item o_result
);
    import lsnr_pkg::*;

    localparam int LAT = RULE_SLOTS + 2;

    // Every result comes from an accepted beat.
    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result without an accepted beat");

    // Only translate beats produce results.
    a_result_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(i_cmd.command, LAT) == CMD_XLATE))
        else $error("result for a rule write");

    // A header that matched nothing passes unchanged.
    a_miss_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.matched) |->
            ((o_result.source_address_out == $past(i_cmd.source_address, LAT))
             && (o_result.header_checksum == $past(i_cmd.hdr_word2[15:0], LAT))))
        else $error("miss altered the header");

    // Right after a reset cycle no result can be pending.
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result right after reset");

endmodule

bind lpm_source_nat_rewrite_unit lsnr_port_checker #(
    .RULE_SLOTS(RULE_SLOTS)
) u_lsnr_port_checker (.*);
